>>> design/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_CLK_RST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_RST(label, clk, prop)
`endif
`endif

>>> design/mfn_pkg.sv
// ----------------------------------------------------------------------------
// mfn_pkg
// Shared constants for the maze flood-fill navigator.
// ----------------------------------------------------------------------------
`default_nettype none
package mfn_pkg;
   localparam int MAZE_SIDE_DEFAULT   = 16;
   localparam int STACK_DEPTH_DEFAULT = 512;
   localparam logic [7:0] GOAL_RESET  = 8'd119;
   localparam logic [7:0] START_CELL  = 8'd16;
   localparam logic [7:0] DIST_MAX    = 8'd255;
   localparam logic [4:0] CELL0_WALLS = 5'h1E;
   localparam logic [4:0] VISITED     = 5'h10;
   localparam logic [16:0] FLOOD_BUDGET = 17'd65536;
   localparam logic [2:0] MOVE_STRAIGHT = 3'd0;
   localparam logic [2:0] MOVE_RIGHT    = 3'd1;
   localparam logic [2:0] MOVE_LEFT     = 3'd2;
   localparam logic [2:0] MOVE_ABOUT    = 3'd3;
   localparam logic [2:0] MOVE_STOP     = 3'd4;

   // Manhattan distance to the centre cells; cells beyond the maze included.
   function automatic logic [7:0] reset_dist(input logic [7:0] cell_idx, input int side);
      int r, c, lo, hi, dr, dc;
      r  = int'(cell_idx[7:4]);
      c  = int'(cell_idx[3:0]);
      lo = (side - 1) / 2;
      hi = side / 2;
      dr = (r < lo) ? lo - r : ((r > hi) ? r - hi : 0);
      dc = (c < lo) ? lo - c : ((c > hi) ? c - hi : 0);
      return 8'(dr + dc);
   endfunction
endpackage
`default_nettype wire

>>> design/maze_floodfill_navigator_unit.sv
// ----------------------------------------------------------------------------
// maze_floodfill_navigator_unit
// Flood-fill micromouse navigator driven by one wall sensing per cell move.
// ----------------------------------------------------------------------------
// Operation: after reset a clearing pass restores every cell's walls and distance.
// A move writes the sensed walls, then pops flood cells; each popped cell whose
// distance changes pushes its open neighbours. A move once halted at the goal stops.
// Throughput: one move at a time; req_tready is low while a move is in work or waits.
// Reset: synchronous, active high; the memories are restored by the clearing pass.
`default_nettype none
`include "assert_macros.svh"
module maze_floodfill_navigator_unit #(
   parameter int MAZE_SIDE   = mfn_pkg::MAZE_SIDE_DEFAULT,
   parameter int STACK_DEPTH = mfn_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // wall_left, wall_right, wall_front, zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // move[2:0], cell_res[10:3], heading[12:11],
                                         // at_goal[13], stack_overflow[14], zero pad
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata
);
   localparam int SW = $clog2(STACK_DEPTH + 1);
   localparam int SA = $clog2(STACK_DEPTH);

   // State codes.
   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_POP = 4'd2, S_RD = 4'd3,
                          S_NB = 4'd4, S_EVAL = 4'd5, S_PUSH = 4'd6, S_SEL = 4'd7,
                          S_OUT = 4'd8, S_POPW = 4'd9, S_CMP = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [7:0]  goal_ff;
   logic [7:0]  pos_ff, pos_in;
   logic [1:0]  face_ff, face_in;
   logic        halt_ff, halt_in;
   logic [SW-1:0] sp_ff, sp_in;
   logic [16:0] pops_ff, pops_in;
   logic        drop_ff, drop_in;
   logic [7:0]  cell_ff, cell_in;
   logic [2:0]  dir_ff, dir_in;     // neighbour scan index, 4 = done
   logic [4:0]  cw_ff, cw_in;       // walls of the cell under work
   logic [7:0]  best_ff, best_in;
   logic [1:0]  bdir_ff, bdir_in;
   logic        any_ff, any_in;
   logic        self_ff, self_in;   // scanning a popped flood cell
   logic [7:0]  own_ff, own_in;
   logic [7:0]  clr_ff, clr_in;
   logic        rsp_v_ff, rsp_v_in;
   logic [14:0] rsp_d_ff, rsp_d_in;

   // Memories.
   logic [4:0]  wall_mem [256];
   logic [7:0]  dist_mem [256];
   logic [7:0]  stk_mem  [STACK_DEPTH];
   logic [4:0]  wall_q;
   logic [7:0]  dist_q, stk_q;
   logic        w_we, d_we, s_we;
   logic [7:0]  w_a, d_a, d_d, s_d;
   logic [4:0]  w_wd;
   logic [SA-1:0] s_a;

   always_ff @(posedge clock) begin
      if (w_we) wall_mem[w_a] <= w_wd;
      wall_q <= wall_mem[w_a];
      if (d_we) dist_mem[d_a] <= d_d;
      dist_q <= dist_mem[d_a];
      if (s_we) stk_mem[s_a] <= s_d;
      stk_q <= stk_mem[s_a];
   end

   // Neighbour of cell_ff in direction dir_ff, with the open test.
   logic [3:0] nr, nc;
   logic       nopen;
   logic [7:0] nb;
   always_comb begin
      nr = cell_ff[7:4];
      nc = cell_ff[3:0];
      nopen = !cw_ff[dir_ff[1:0]];
      case (dir_ff[1:0])
         2'd0: nr = nr + 4'd1;
         2'd1: nc = nc + 4'd1;
         2'd2: begin
            if (nr == 4'd0) nopen = 1'b0;
            nr = nr - 4'd1;
         end
         default: begin
            if (nc == 4'd0) nopen = 1'b0;
            nc = nc - 4'd1;
         end
      endcase
      if ((dir_ff[1:0] == 2'd0 && 5'(cell_ff[7:4]) + 5'd1 >= 5'(MAZE_SIDE)) ||
          (dir_ff[1:0] == 2'd1 && 5'(cell_ff[3:0]) + 5'd1 >= 5'(MAZE_SIDE)))
         nopen = 1'b0;
      nb = {nr, nc};
   end

   logic [7:0] target;
   assign target = (best_ff < mfn_pkg::DIST_MAX) ? best_ff + 8'd1 : best_ff;
   logic [1:0] rel;
   assign rel = bdir_ff - face_ff;

   always_comb begin
      state_in = state_ff; pos_in = pos_ff; face_in = face_ff; halt_in = halt_ff;
      sp_in = sp_ff; pops_in = pops_ff; drop_in = drop_ff; cell_in = cell_ff;
      dir_in = dir_ff; cw_in = cw_ff; best_in = best_ff; bdir_in = bdir_ff;
      any_in = any_ff; self_in = self_ff; own_in = own_ff; clr_in = clr_ff;
      rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff;
      w_we = 1'b0; d_we = 1'b0; s_we = 1'b0;
      w_a = cell_ff; w_wd = '0; d_a = nb; d_d = target;
      s_a = SA'(sp_ff); s_d = nb;
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            w_we = 1'b1; w_a = clr_ff;
            w_wd = (clr_ff == 8'd0) ? (mfn_pkg::VISITED | mfn_pkg::CELL0_WALLS) : 5'd0;
            d_we = 1'b1; d_a = clr_ff; d_d = mfn_pkg::reset_dist(clr_ff, MAZE_SIDE);
            clr_in = clr_ff + 8'd1;
            if (clr_ff == 8'd255) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && !rsp_v_ff) begin
               if (halt_ff) begin
                  rsp_v_in = 1'b1;
                  rsp_d_in = {1'b0, 1'b1, face_ff, pos_ff, mfn_pkg::MOVE_STOP};
               end else begin
                  w_we = 1'b1; w_a = pos_ff;
                  w_wd = mfn_pkg::VISITED;
                  w_wd[face_ff]        = req_tdata[2];
                  w_wd[face_ff + 2'd1] = req_tdata[1];
                  w_wd[face_ff + 2'd3] = req_tdata[0];
                  s_we = 1'b1; s_a = '0; s_d = pos_ff;
                  sp_in = SW'(1); pops_in = '0; drop_in = 1'b0;
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            if (sp_ff == '0 || pops_ff == mfn_pkg::FLOOD_BUDGET) begin
               cell_in = pos_ff; state_in = S_RD; self_in = 1'b0;
               dir_in = 3'd7; // marks the final selection scan
            end else begin
               sp_in = sp_ff - SW'(1); pops_in = pops_ff + 17'd1;
               s_a = SA'(sp_ff - SW'(1));
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            cell_in = stk_q; state_in = S_RD; self_in = 1'b1; dir_in = 3'd0;
         end
         S_RD: begin
            // Read the walls and own distance of the cell.
            w_a = cell_ff; d_a = cell_ff;
            any_in = 1'b0; best_in = mfn_pkg::DIST_MAX; bdir_in = 2'd0;
            state_in = S_NB;
         end
         S_NB: begin
            cw_in = wall_q; own_in = dist_q; state_in = S_EVAL;
            if (dir_ff == 3'd7) dir_in = 3'd0;
         end
         S_EVAL: begin
            // Scan one direction at a time: issue the read here, then compare in S_CMP.
            if (dir_ff[2]) begin
               if (self_ff) begin
                  if (cell_ff != goal_ff && own_ff != target) begin
                     d_we = 1'b1; d_a = cell_ff; d_d = target;
                     dir_in = 3'd0; state_in = S_PUSH;
                  end else state_in = S_POP;
               end else state_in = S_SEL;
            end else begin
               d_a = nb;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (nopen) begin
               if (!any_ff || dist_q < best_ff) begin
                  best_in = dist_q; bdir_in = dir_ff[1:0];
               end
               any_in = 1'b1;
            end
            dir_in = dir_ff + 3'd1;
            state_in = S_EVAL;
         end
         S_PUSH: begin
            if (dir_ff[2]) state_in = S_POP;
            else begin
               if (nopen) begin
                  if (sp_ff >= SW'(STACK_DEPTH)) drop_in = 1'b1;
                  else begin
                     s_we = 1'b1; s_a = SA'(sp_ff); s_d = nb; sp_in = sp_ff + SW'(1);
                  end
               end
               dir_in = dir_ff + 3'd1;
            end
         end
         S_SEL: begin
            state_in = S_IDLE;
            rsp_v_in = 1'b1;
            if (pos_ff == goal_ff) begin
               halt_in = 1'b1;
               rsp_d_in = {drop_ff, 1'b1, face_ff, pos_ff, mfn_pkg::MOVE_STOP};
            end else if (any_ff) begin
               cell_in = pos_ff; dir_in = {1'b0, bdir_ff};
               state_in = S_OUT; rsp_v_in = 1'b0;
            end else begin
               rsp_d_in = {drop_ff, 1'b0, face_ff, pos_ff, mfn_pkg::MOVE_STRAIGHT};
            end
         end
         S_OUT: begin
            // Turn toward the chosen open side and step through it.
            pos_in = nb;
            face_in = bdir_ff;
            rsp_v_in = 1'b1;
            rsp_d_in = {drop_ff, (nb == goal_ff), bdir_ff, nb,
                        (rel == 2'd0) ? mfn_pkg::MOVE_STRAIGHT :
                        (rel == 2'd1) ? mfn_pkg::MOVE_RIGHT :
                        (rel == 2'd3) ? mfn_pkg::MOVE_LEFT : mfn_pkg::MOVE_ABOUT};
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; goal_ff <= mfn_pkg::GOAL_RESET;
         pos_ff <= mfn_pkg::START_CELL; face_ff <= 2'd0; halt_ff <= 1'b0;
         sp_ff <= '0; clr_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pos_ff <= pos_in; face_ff <= face_in;
         halt_ff <= halt_in; sp_ff <= sp_in; clr_ff <= clr_in; rsp_v_ff <= rsp_v_in;
         if (csr_we) goal_ff <= csr_wdata;
      end
      pops_ff <= pops_in; drop_ff <= drop_in; cell_ff <= cell_in; dir_ff <= dir_in;
      cw_ff <= cw_in; best_ff <= best_in; bdir_ff <= bdir_in; any_ff <= any_in;
      self_ff <= self_in; own_ff <= own_in; rsp_d_ff <= rsp_d_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {1'b0, rsp_d_ff};

   `ASSERT_CLK(a_busy_no_rsp, clock, reset, (state_ff != S_IDLE) |-> !req_tready)
   `ASSERT_CLK(a_sp_bound, clock, reset, sp_ff <= SW'(STACK_DEPTH))
   `ASSERT_CLK(a_rsp_move, clock, reset, rsp_v_ff |-> rsp_d_ff[2:0] <= mfn_pkg::MOVE_STOP)
endmodule
`default_nettype wire
